FILE: src/dkm_pkg.sv
// ---------------------------------------------------------------------------
// dkm_pkg: shared constants for the keyed djb2 MAC
// Seed, reset values and configuration register indexes.
// ---------------------------------------------------------------------------
package dkm_pkg;

  localparam int unsigned DIGEST_W  = 64;
  localparam int unsigned KEY_LEN_W = 4;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 64;

  // djb2 starting value
  localparam logic [DIGEST_W-1:0] DJB2_SEED = 64'd5381;

  // configuration reset values
  localparam logic [DIGEST_W-1:0]  KEY_BYTES_RESET  = '0;
  localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = 4'd8;

  // register indexes (paddr bit 3 selects the register)
  localparam logic REG_KEY_BYTES  = 1'b0;
  localparam logic REG_KEY_LENGTH = 1'b1;

endpackage

FILE: src/djb2_keyed_mac.sv
// ---------------------------------------------------------------------------
// djb2_keyed_mac: keyed 64-bit djb2 MAC over a byte stream
// Hashes at most one byte per transaction and emits digest XOR key stream with a
// match flag on the transaction marked last.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  in_     | in_valid/in_ready   | data_byte, has_byte, is_last, expected_mac
//  out_    | out_valid/out_ready | mac_value, mac_matches
//  APB     | psel/penable        | key_bytes @0x0, key_length @0x8
//
// One transaction per cycle while in_ready is high; the 64-bit shift-add and
// compare sit between the accumulator and the result register, so a result
// appears in the cycle after its last transaction. in_ready drops only while
// a result is held and out_ready is low. Synchronous reset reseeds the digest
// to 5381 and sets key length to 8.
// ---------------------------------------------------------------------------
module djb2_keyed_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_has_byte,
  input  logic                          in_is_last,
  input  logic [dkm_pkg::DIGEST_W-1:0]  in_expected_mac,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dkm_pkg::DIGEST_W-1:0]  out_mac_value,
  output logic                          out_mac_matches,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dkm_pkg::PADDR_W-1:0]   paddr,
  input  logic [dkm_pkg::PDATA_W-1:0]   pwdata,
  output logic [dkm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import dkm_pkg::*;

  logic [DIGEST_W-1:0] key_stream;

  assign pready = 1'b1;

  // configuration
  dkm_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .key_stream (key_stream)
  );

  // datapath
  dkm_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_has_byte     (in_has_byte),
    .in_is_last      (in_is_last),
    .in_expected_mac (in_expected_mac),
    .key_stream      (key_stream),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_mac_value   (out_mac_value),
    .out_mac_matches (out_mac_matches)
  );

endmodule

FILE: src/dkm_regs.sv
// ---------------------------------------------------------------------------
// dkm_regs: configuration registers and key stream
// Holds key bytes and key length behind the APB port and builds the
// cyclically repeated 64-bit key stream from them.
// ---------------------------------------------------------------------------
module dkm_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dkm_pkg::PADDR_W-1:0]     paddr,
  input  logic [dkm_pkg::PDATA_W-1:0]     pwdata,
  output logic [dkm_pkg::PDATA_W-1:0]     prdata,
  output logic [dkm_pkg::DIGEST_W-1:0]    key_stream
);
  import dkm_pkg::*;

  logic [DIGEST_W-1:0]  key_bytes_r;
  logic [KEY_LEN_W-1:0] key_length_r;
  logic                 reg_sel;
  logic                 wr_en;
  logic [2:0]           len_idx;
  logic [DIGEST_W-1:0]  ks_cand [8];

  assign reg_sel = paddr[PADDR_W-1];
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r  <= KEY_BYTES_RESET;
      key_length_r <= KEY_LENGTH_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_KEY_BYTES:  key_bytes_r  <= pwdata[DIGEST_W-1:0];
        REG_KEY_LENGTH: key_length_r <= pwdata[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_sel)
      REG_KEY_BYTES:  prdata = key_bytes_r;
      REG_KEY_LENGTH: prdata = {{(PDATA_W-KEY_LEN_W){1'b0}}, key_length_r};
      default:        prdata = '0;
    endcase
  end

  // clamp length to 1..8, kept as length minus one
  always_comb begin
    if (key_length_r == '0) begin
      len_idx = 3'd0;
    end else if (key_length_r > 4'd8) begin
      len_idx = 3'd7;
    end else begin
      len_idx = 3'(key_length_r - 4'd1);
    end
  end

  // one candidate stream per key length; byte i takes key byte i mod length
  for (genvar l = 1; l <= 8; l++) begin : g_len
    for (genvar i = 0; i < 8; i++) begin : g_byte
      localparam int SRC_BYTE = i % l;
      assign ks_cand[l-1][8*i +: 8] = key_bytes_r[8*SRC_BYTE +: 8];
    end
  end

  assign key_stream = ks_cand[len_idx];

endmodule

FILE: src/dkm_core.sv
// ---------------------------------------------------------------------------
// dkm_core: djb2 accumulator and result register
// Folds at most one byte per transaction into the digest and, on the last one,
// registers the keyed MAC and its compare flag.
// ---------------------------------------------------------------------------
module dkm_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_has_byte,
  input  logic                          in_is_last,
  input  logic [dkm_pkg::DIGEST_W-1:0]  in_expected_mac,
  input  logic [dkm_pkg::DIGEST_W-1:0]  key_stream,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dkm_pkg::DIGEST_W-1:0]  out_mac_value,
  output logic                          out_mac_matches
);
  import dkm_pkg::*;

  logic [DIGEST_W-1:0] acc_r;
  logic [DIGEST_W-1:0] acc_nxt;
  logic [DIGEST_W-1:0] mac_nxt;
  logic [DIGEST_W-1:0] mac_r;
  logic                match_r;
  logic                out_valid_r;
  logic                in_fire;

  // result slot frees up in the same cycle it is taken
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // hash*33 + byte, modulo 2^64, when the transaction has a byte
  assign acc_nxt = in_has_byte
                   ? (acc_r + (acc_r << 5) + {{(DIGEST_W-8){1'b0}}, in_data_byte})
                   : acc_r;
  assign mac_nxt = acc_nxt ^ key_stream;

  // accumulator, reseeded after each message
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= DJB2_SEED;
    end else if (in_fire) begin
      acc_r <= in_is_last ? DJB2_SEED : acc_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire && in_is_last) begin
      mac_r   <= mac_nxt;
      match_r <= (mac_nxt == in_expected_mac);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mac_value   = mac_r;
  assign out_mac_matches = match_r;

endmodule

FILE: src/dkm_checker.sv
// ---------------------------------------------------------------------------
// dkm_checker: port-level checks for djb2_keyed_mac
// Watches the top-level handshakes and results over time.
// ---------------------------------------------------------------------------
module dkm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_is_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_mac_value,
  input logic        out_mac_matches
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mac_value)
      && $stable(out_mac_matches))
    else $error("result changed while stalled");

  // a last transaction always produces a result next cycle
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> out_valid)
    else $error("missing result after last transaction");

  // no result appears without a last transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) && !(in_valid && in_ready && in_is_last) |=> !out_valid)
    else $error("result without last transaction");

  // input stalls only behind a held result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input stalled without a pending result");

  // reset empties the result slot
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind djb2_keyed_mac dkm_checker u_dkm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_is_last      (in_is_last),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_mac_value   (out_mac_value),
  .out_mac_matches (out_mac_matches)
);
